// ===== sv/spin_backoff_controller_assert.svh =====
// Assertion shorthands for the checker of the backoff controller.
`ifndef SPIN_BACKOFF_CONTROLLER_ASSERT_SVH
`define SPIN_BACKOFF_CONTROLLER_ASSERT_SVH

// Consequent checked in the same cycle, suspended while reset is low.
`define SBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the next cycle, suspended while reset is low.
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the next cycle, active during reset too.
`define SBC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sbc_pkg.sv =====
package sbc_pkg;

    // Field widths fixed by the event and result formats
    localparam int ACTION_W   = 3;
    localparam int SPIN_W     = 10;
    localparam int TALLY_W    = 11;
    localparam int USEC_W     = 20;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    // Result transaction: 53 payload bits padded to whole bytes
    localparam int OUT_TDATA_W = 56;

    localparam logic [SPIN_W-1:0] SPIN_SAT = 10'd1023;

    // Blend is (15*shared + budget) / 16
    localparam logic [3:0] BLEND_WEIGHT = 4'd15;
    localparam int         BLEND_SHIFT  = 4;

    // Reset values of the configuration registers
    localparam logic [SPIN_W-1:0]     RST_INITIAL_SPINS = 10'd100;
    localparam logic [SPIN_W-1:0]     RST_MIN_SPINS     = 10'd10;
    localparam logic [SPIN_W-1:0]     RST_MAX_SPINS     = 10'd1000;
    localparam logic [SPIN_W-1:0]     RST_SPINS_INC     = 10'd100;
    localparam logic [SPIN_W-1:0]     RST_MAX_DELAYS    = 10'd1000;
    localparam logic [CFG_DATA_W-1:0] RST_MIN_DELAY     = 20'd1000;
    localparam logic [CFG_DATA_W-1:0] RST_MAX_DELAY     = 20'd1000000;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_SPINS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPINS     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPINS     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPINS_INC     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DELAYS    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_DELAY     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DELAY     = 3'd6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START   = 3'd0,
        ACT_FAIL    = 3'd1,
        ACT_ACQUIRE = 3'd2,
        ACT_LOAD    = 3'd3,
        ACT_BLEND   = 3'd4
    } t_action;

    typedef struct packed {
        logic [SPIN_W-1:0]     min_spins;
        logic [SPIN_W-1:0]     max_spins;
        logic [SPIN_W-1:0]     spins_increment;
        logic [SPIN_W-1:0]     max_delays;
        logic [CFG_DATA_W-1:0] min_delay_us;
        logic [CFG_DATA_W-1:0] max_delay_us;
    } t_cfg;

    // Counter part of the wait state (the delay itself is sized by a parameter)
    typedef struct packed {
        logic [SPIN_W-1:0]  spin_count;
        logic [TALLY_W-1:0] delay_tally;
        logic [SPIN_W-1:0]  budget;
        logic               stuck;
    } t_ctr;

    typedef struct packed {
        logic [SPIN_W-1:0]  blended_estimate;
        logic [SPIN_W-1:0]  spin_budget;
        logic [TALLY_W-1:0] delay_count;
        logic               stuck;
        logic [USEC_W-1:0]  sleep_usec;
        logic               sleep_request;
    } t_result;

endpackage

// ===== sv/sbc_cfg.sv =====
module sbc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sbc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [sbc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output sbc_pkg::t_cfg                    o_cfg
);

    sbc_pkg::t_cfg r_cfg;

    // Hold the configuration registers; the initial budget is only seen at reset,
    // and reset always restores its default, so a write to it keeps no storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_spins       <= sbc_pkg::RST_MIN_SPINS;
            r_cfg.max_spins       <= sbc_pkg::RST_MAX_SPINS;
            r_cfg.spins_increment <= sbc_pkg::RST_SPINS_INC;
            r_cfg.max_delays      <= sbc_pkg::RST_MAX_DELAYS;
            r_cfg.min_delay_us    <= sbc_pkg::RST_MIN_DELAY;
            r_cfg.max_delay_us    <= sbc_pkg::RST_MAX_DELAY;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sbc_pkg::REG_MIN_SPINS:  r_cfg.min_spins       <= i_cfg_wdata[sbc_pkg::SPIN_W-1:0];
                sbc_pkg::REG_MAX_SPINS:  r_cfg.max_spins       <= i_cfg_wdata[sbc_pkg::SPIN_W-1:0];
                sbc_pkg::REG_SPINS_INC:  r_cfg.spins_increment <= i_cfg_wdata[sbc_pkg::SPIN_W-1:0];
                sbc_pkg::REG_MAX_DELAYS: r_cfg.max_delays      <= i_cfg_wdata[sbc_pkg::SPIN_W-1:0];
                sbc_pkg::REG_MIN_DELAY:  r_cfg.min_delay_us    <= i_cfg_wdata;
                sbc_pkg::REG_MAX_DELAY:  r_cfg.max_delay_us    <= i_cfg_wdata;
                default: begin
                    // initial budget and unused indexes: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/sbc_step.sv =====
module sbc_step #(
    parameter int FRACTION_BITS = 16,
    parameter int DELAY_BITS    = 20
) (
    input  logic [sbc_pkg::ACTION_W-1:0] i_action,
    input  logic [FRACTION_BITS-1:0]     i_frac,
    input  logic [sbc_pkg::SPIN_W-1:0]   i_shared,
    input  sbc_pkg::t_cfg                i_cfg,
    input  sbc_pkg::t_ctr                i_ctr,
    input  logic [DELAY_BITS-1:0]        i_delay,
    output sbc_pkg::t_ctr                o_ctr,
    output logic [DELAY_BITS-1:0]        o_delay,
    output sbc_pkg::t_result             o_result
);

    localparam int PROD_W = DELAY_BITS + FRACTION_BITS;

    // Rounding constant: one half in Q0.FRACTION_BITS
    localparam logic [PROD_W:0] HALF =
        {{(DELAY_BITS + 1){1'b0}}, 1'b1, {(FRACTION_BITS - 1){1'b0}}};

    logic [sbc_pkg::SPIN_W-1:0]                     spin_inc;
    logic                                           fire;
    logic [sbc_pkg::TALLY_W-1:0]                    tally_lim;
    logic [sbc_pkg::TALLY_W-1:0]                    tally_inc;
    logic [DELAY_BITS+sbc_pkg::CFG_DATA_W-1:0]      min_ext;
    logic [DELAY_BITS-1:0]                          min_d;
    logic [DELAY_BITS-1:0]                          cd_eff;
    logic [PROD_W-1:0]                              prod;
    logic [PROD_W:0]                                prod_rnd;
    logic [DELAY_BITS:0]                            growth;
    logic [DELAY_BITS+1:0]                          grown;
    logic                                           over_max;
    logic [DELAY_BITS-1:0]                          next_delay;
    logic [DELAY_BITS+sbc_pkg::USEC_W-1:0]          usec_ext;
    logic [sbc_pkg::SPIN_W:0]                       raise_sum;
    logic [sbc_pkg::SPIN_W-1:0]                     raised;
    logic [sbc_pkg::SPIN_W-1:0]                     lowered;
    logic [sbc_pkg::SPIN_W+4:0]                     blend_sum;

    // Spin count with saturation and the sleep decision
    assign spin_inc = (i_ctr.spin_count < sbc_pkg::SPIN_SAT) ?
                      i_ctr.spin_count + 1'b1 : i_ctr.spin_count;
    assign fire     = (spin_inc >= i_ctr.budget);

    // Delay tally saturates one past the allowed number of sleeps
    assign tally_lim = {1'b0, i_cfg.max_delays} + 1'b1;
    assign tally_inc = (i_ctr.delay_tally < tally_lim) ?
                       i_ctr.delay_tally + 1'b1 : i_ctr.delay_tally;

    // A wait that never slept starts at the minimum delay
    assign min_ext = {{DELAY_BITS{1'b0}}, i_cfg.min_delay_us};
    assign min_d   = min_ext[DELAY_BITS-1:0];
    assign cd_eff  = (i_delay == '0) ? min_d : i_delay;

    // Grow by round(delay * fraction), wrap to the minimum above the maximum
    assign prod      = cd_eff * i_frac;
    assign prod_rnd  = {1'b0, prod} + HALF;
    assign growth    = prod_rnd[PROD_W:FRACTION_BITS];
    assign grown     = {2'b00, cd_eff} + {1'b0, growth};
    assign over_max  = ({{sbc_pkg::CFG_DATA_W{1'b0}}, grown} >
                        {{(DELAY_BITS + 2){1'b0}}, i_cfg.max_delay_us});
    assign next_delay = over_max ? min_d : grown[DELAY_BITS-1:0];
    assign usec_ext  = {{sbc_pkg::USEC_W{1'b0}}, cd_eff};

    // Budget adaptation on acquire
    assign raise_sum = {1'b0, i_ctr.budget} + {1'b0, i_cfg.spins_increment};
    assign raised    = (raise_sum > {1'b0, i_cfg.max_spins}) ?
                       i_cfg.max_spins : raise_sum[sbc_pkg::SPIN_W-1:0];
    assign lowered   = i_ctr.budget - 1'b1;

    // Moving average: 15*shared as 16*shared - shared
    assign blend_sum = {1'b0, i_shared, 4'b0000} - {5'b00000, i_shared}
                       + {5'b00000, i_ctr.budget};

    // Apply the event to the wait state and build the result
    always_comb begin
        o_ctr                     = i_ctr;
        o_delay                   = i_delay;
        o_result.sleep_request    = 1'b0;
        o_result.sleep_usec       = '0;
        o_result.blended_estimate = '0;
        case (sbc_pkg::t_action'(i_action))
            sbc_pkg::ACT_START: begin
                o_ctr.spin_count  = '0;
                o_ctr.delay_tally = '0;
                o_ctr.stuck       = 1'b0;
                o_delay           = '0;
            end
            sbc_pkg::ACT_FAIL: begin
                o_ctr.spin_count = spin_inc;
                if (fire) begin
                    o_ctr.spin_count       = '0;
                    o_ctr.delay_tally      = tally_inc;
                    o_ctr.stuck            = i_ctr.stuck |
                                             (tally_inc > {1'b0, i_cfg.max_delays});
                    o_delay                = next_delay;
                    o_result.sleep_request = 1'b1;
                    o_result.sleep_usec    = usec_ext[sbc_pkg::USEC_W-1:0];
                end
            end
            sbc_pkg::ACT_ACQUIRE: begin
                if (i_delay == '0) begin
                    if (i_ctr.budget < i_cfg.max_spins) begin
                        o_ctr.budget = raised;
                    end
                end else if (i_ctr.budget > i_cfg.min_spins) begin
                    o_ctr.budget = lowered;
                end
            end
            sbc_pkg::ACT_LOAD: begin
                o_ctr.budget = i_shared;
            end
            sbc_pkg::ACT_BLEND: begin
                o_result.blended_estimate =
                    blend_sum[sbc_pkg::SPIN_W+sbc_pkg::BLEND_SHIFT-1:sbc_pkg::BLEND_SHIFT];
            end
            default: begin
                // unused codes: report status only
            end
        endcase
        o_result.stuck       = o_ctr.stuck;
        o_result.delay_count = o_ctr.delay_tally;
        o_result.spin_budget = o_ctr.budget;
    end

endmodule

// ===== sv/spin_backoff_controller.sv =====
// Flow: the input register loads on the accepting edge; the result register loads
// when it is free or draining. Throughput: one event per cycle unless results stall;
// the next event uses the state left by the previous one through a single
// combinational step with one delay*fraction multiply.
// Reset (synchronous, active low): wait state, budget and configuration return
// to their defaults; both stages empty.
module spin_backoff_controller #(
    parameter int FRACTION_BITS = 16,
    parameter int DELAY_BITS    = 20
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // event stream
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata: action[3], random_fraction[FRACTION_BITS], shared_estimate[10], zero pad
    input  logic [((sbc_pkg::ACTION_W + FRACTION_BITS + sbc_pkg::SPIN_W + 7) / 8) * 8 - 1:0]
                                                   i_s_axis_tdata,
    // result stream
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // tdata: sleep_request[1], sleep_usec[20], stuck[1], delay_count[11],
    //        spin_budget[10], blended_estimate[10], zero pad[3]
    output logic [sbc_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [sbc_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [sbc_pkg::CFG_DATA_W-1:0]         i_cfg_wdata
);

    localparam int FRAC_LO   = sbc_pkg::ACTION_W;
    localparam int SHARED_LO = sbc_pkg::ACTION_W + FRACTION_BITS;

    sbc_pkg::t_cfg                cfg;
    sbc_pkg::t_ctr                n_ctr;
    sbc_pkg::t_result             n_out;
    logic [DELAY_BITS-1:0]        n_delay;
    logic                         advance;

    logic                         r_in_valid;
    logic [sbc_pkg::ACTION_W-1:0] r_action;
    logic [FRACTION_BITS-1:0]     r_frac;
    logic [sbc_pkg::SPIN_W-1:0]   r_shared;
    sbc_pkg::t_ctr                r_ctr;
    logic [DELAY_BITS-1:0]        r_delay;
    logic                         r_out_valid;
    sbc_pkg::t_result             r_out;

    sbc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    sbc_step #(
        .FRACTION_BITS (FRACTION_BITS),
        .DELAY_BITS    (DELAY_BITS)
    ) u_step (
        .i_action (r_action),
        .i_frac   (r_frac),
        .i_shared (r_shared),
        .i_cfg    (cfg),
        .i_ctr    (r_ctr),
        .i_delay  (r_delay),
        .o_ctr    (n_ctr),
        .o_delay  (n_delay),
        .o_result (n_out)
    );

    // Advance the held event when the result register is free or draining
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_action <= i_s_axis_tdata[sbc_pkg::ACTION_W-1:0];
            r_frac   <= i_s_axis_tdata[FRAC_LO +: FRACTION_BITS];
            r_shared <= i_s_axis_tdata[SHARED_LO +: sbc_pkg::SPIN_W];
        end
    end

    // Wait state and result register, updated together per event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr.spin_count  <= '0;
            r_ctr.delay_tally <= '0;
            r_ctr.budget      <= sbc_pkg::RST_INITIAL_SPINS;
            r_ctr.stuck       <= 1'b0;
            r_delay           <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (advance) begin
                r_ctr   <= n_ctr;
                r_delay <= n_delay;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out};

endmodule

// ===== sv/sbc_checker.sv =====
`include "spin_backoff_controller_assert.svh"

module sbc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [sbc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // A stalled result holds its payload
    `SBC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")

    // No sleep length without a sleep request
    `SBC_ASSERT_SAME(a_usec_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[0], o_m_axis_tdata[20:1] == 20'd0, "sleep length without request")

    // Delay count never passes the largest limit plus one
    `SBC_ASSERT_SAME(a_tally_range, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[32:22] <= 11'd1024, "delay count out of range")

    // Event taken while the result stalls fills the input stage; still stalled means not ready
    `SBC_ASSERT_SAME(a_fill_stall, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready && i_s_axis_tvalid && o_s_axis_tready) ##1 !i_m_axis_tready, !o_s_axis_tready, "both stages full but still ready")

    // Reset empties the result stage
    `SBC_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_m_axis_tvalid, "result valid after reset")

endmodule

bind spin_backoff_controller sbc_checker u_sbc_checker (.*);

// ===== bench/tb_spin_backoff_controller.sv =====
`timescale 1ns / 100ps

module tb_spin_backoff_controller;

    localparam int FRAC_W    = 16;
    localparam int DELAY_W   = 20;
    localparam int ACT_BITS  = sbc_pkg::ACTION_W;
    localparam int SPIN_BITS = sbc_pkg::SPIN_W;
    localparam int CFG_BITS  = sbc_pkg::CFG_DATA_W;
    localparam int EV_W      = ((sbc_pkg::ACTION_W + FRAC_W + sbc_pkg::SPIN_W + 7) / 8) * 8;
    localparam int RES_W     = $bits(sbc_pkg::t_result);

    localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAC_W - 1);

    // Action codes the block does not define; they must leave the state alone
    localparam logic [sbc_pkg::ACTION_W-1:0] ACT_RSVD5 = 3'd5;
    localparam logic [sbc_pkg::ACTION_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [sbc_pkg::ACTION_W-1:0] ACT_RSVD7 = 3'd7;

    // Register index with no register behind it
    localparam logic [sbc_pkg::CFG_ADDR_W-1:0] REG_NONE = 3'd7;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int RX_HOLD_CYCLES = 250;

    typedef struct {
        logic [sbc_pkg::ACTION_W-1:0] action;
        logic [FRAC_W-1:0]            frac;
        logic [sbc_pkg::SPIN_W-1:0]   shared;
    } t_lock_event;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_s_axis_tvalid = 1'b0;
    logic                               o_s_axis_tready;
    // tdata: action[3], random_fraction[16], shared_estimate[10], zero pad[3]
    logic [EV_W-1:0]                    i_s_axis_tdata = '0;
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready = 1'b0;
    // tdata: sleep_request, sleep_usec, stuck, delay_count, spin_budget,
    //        blended_estimate, zero pad
    logic [sbc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata;
    logic                               i_cfg_we = 1'b0;
    logic [sbc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr = '0;
    logic [sbc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata = '0;

    // Predictor state and register shadow
    sbc_pkg::t_cfg                      cfg;
    logic [sbc_pkg::SPIN_W-1:0]         cfg_initial;
    logic [sbc_pkg::SPIN_W-1:0]         spin_cnt;
    logic [sbc_pkg::TALLY_W-1:0]        tally;
    logic [DELAY_W-1:0]                 pred_delay;
    logic [sbc_pkg::SPIN_W-1:0]         budget;
    logic                               stuck_q;

    t_lock_event                        event_q[$];
    sbc_pkg::t_result                   pending_status[$];

    bit                                 ev_taken;
    bit                                 tx_idle_on;
    bit                                 rx_idle_on;
    bit                                 rx_hold_req;
    int                                 tx_gap;
    int                                 rx_gap;
    int                                 rx_hold_left;
    int                                 n_err;
    int                                 cycle_cnt;

    spin_backoff_controller u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_spin_backoff_controller NOT OK");
            $finish;
        end
    end

    // Advance the backoff state by one event and return the status it reports
    function automatic sbc_pkg::t_result step_backoff(logic [sbc_pkg::ACTION_W-1:0] act,
                                                      logic [FRAC_W-1:0] frac,
                                                      logic [sbc_pkg::SPIN_W-1:0] shared);
        sbc_pkg::t_result r;
        logic [63:0]      grown;
        logic [31:0]      nb;
        r = '0;
        case (act)
            sbc_pkg::ACT_START: begin
                spin_cnt   = '0;
                tally      = '0;
                pred_delay = '0;
                stuck_q    = 1'b0;
            end
            sbc_pkg::ACT_FAIL: begin
                if (spin_cnt < sbc_pkg::SPIN_SAT)
                    spin_cnt = spin_cnt + 1'b1;
                if (spin_cnt >= budget) begin
                    if (32'(tally) < 32'(cfg.max_delays) + 32'd1)
                        tally = tally + 1'b1;
                    if (32'(tally) > 32'(cfg.max_delays))
                        stuck_q = 1'b1;
                    if (pred_delay == '0)
                        pred_delay = cfg.min_delay_us[DELAY_W-1:0];
                    r.sleep_request = 1'b1;
                    r.sleep_usec    = pred_delay;
                    // grow by delay * f, rounded to nearest
                    grown = 64'(pred_delay)
                          + ((64'(pred_delay) * 64'(frac) + ROUND_HALF) >> FRAC_W);
                    if (grown > 64'(cfg.max_delay_us))
                        grown = 64'(cfg.min_delay_us);
                    pred_delay = grown[DELAY_W-1:0];
                    spin_cnt   = '0;
                end
            end
            sbc_pkg::ACT_ACQUIRE: begin
                if (pred_delay == '0) begin
                    // never slept: raise by the step, clamp at the top
                    if (budget < cfg.max_spins) begin
                        nb = 32'(budget) + 32'(cfg.spins_increment);
                        budget = (nb > 32'(cfg.max_spins)) ? cfg.max_spins
                                                           : nb[sbc_pkg::SPIN_W-1:0];
                    end
                end else if (budget > cfg.min_spins) begin
                    budget = budget - 1'b1;
                end
            end
            sbc_pkg::ACT_LOAD: begin
                budget = shared;
            end
            sbc_pkg::ACT_BLEND: begin
                nb = (32'(shared) * 32'(sbc_pkg::BLEND_WEIGHT) + 32'(budget))
                     >> sbc_pkg::BLEND_SHIFT;
                r.blended_estimate = nb[sbc_pkg::SPIN_W-1:0];
            end
            default: begin
            end
        endcase
        r.stuck       = stuck_q;
        r.delay_count = tally;
        r.spin_budget = budget;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 50)
            return 0;
        else if (p < 85)
            return $urandom_range(3, 1);
        else if (p < 96)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    // Predict on each accepted event transaction
    always @(posedge i_clk) begin
        ev_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (ev_taken)
            pending_status.push_back(step_backoff(i_s_axis_tdata[sbc_pkg::ACTION_W-1:0],
                i_s_axis_tdata[sbc_pkg::ACTION_W +: FRAC_W],
                i_s_axis_tdata[sbc_pkg::ACTION_W + FRAC_W +: sbc_pkg::SPIN_W]));
    end

    task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            n_err++;
        end
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        sbc_pkg::t_result got;
        sbc_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = sbc_pkg::t_result'(o_m_axis_tdata[RES_W-1:0]);
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         o_m_axis_tdata);
                n_err++;
            end else begin
                want = pending_status.pop_front();
                check_field("sleep_request", want.sleep_request, got.sleep_request);
                check_field("sleep_usec", want.sleep_usec, got.sleep_usec);
                check_field("stuck", want.stuck, got.stuck);
                check_field("delay_count", want.delay_count, got.delay_count);
                check_field("spin_budget", want.spin_budget, got.spin_budget);
                check_field("blended_estimate", want.blended_estimate, got.blended_estimate);
            end
        end
    end

    // Event driver: offer the next queued event once the slot is free
    always @(negedge i_clk) begin
        t_lock_event ev;
        if (i_rst_n && (ev_taken || !i_s_axis_tvalid)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (event_q.size() > 0) begin
                ev = event_q.pop_front();
                i_s_axis_tdata  <= EV_W'({ev.shared, ev.frac, ev.action});
                i_s_axis_tvalid <= 1'b1;
                if (tx_idle_on)
                    tx_gap = pick_gap();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (rx_idle_on)
                rx_gap = pick_gap();
        end
    end

    function automatic void push_ev(logic [sbc_pkg::ACTION_W-1:0] a, logic [FRAC_W-1:0] f,
                                    logic [sbc_pkg::SPIN_W-1:0] s);
        t_lock_event ev;
        ev.action = a;
        ev.frac   = f;
        ev.shared = s;
        event_q.push_back(ev);
    endfunction

    // Mostly whole waits (start, failed tries, acquire) with some noise in between
    function automatic void push_random(int n);
        int left;
        int k;
        left = n;
        while (left > 0) begin
            if ($urandom_range(99) < 70) begin
                if ($urandom_range(3) == 0) begin
                    push_ev(sbc_pkg::ACT_LOAD, FRAC_W'($urandom),
                            ($urandom_range(3) == 0) ? SPIN_BITS'($urandom)
                                                     : SPIN_BITS'($urandom_range(6)));
                    left--;
                end
                push_ev(sbc_pkg::ACT_START, FRAC_W'($urandom), SPIN_BITS'($urandom));
                k = $urandom_range(12, 1);
                repeat (k) push_ev(sbc_pkg::ACT_FAIL, FRAC_W'($urandom), SPIN_BITS'($urandom));
                if ($urandom_range(4) == 0) begin
                    push_ev(sbc_pkg::ACT_BLEND, FRAC_W'($urandom), SPIN_BITS'($urandom));
                    left--;
                end
                push_ev(sbc_pkg::ACT_ACQUIRE, FRAC_W'($urandom), SPIN_BITS'($urandom));
                left -= k + 2;
            end else begin
                push_ev(ACT_BITS'($urandom_range(7)), FRAC_W'($urandom), SPIN_BITS'($urandom));
                left--;
            end
        end
    endfunction

    // Hold until every queued event is sent and every result has come back
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
            #1;
        end while (event_q.size() != 0 || i_s_axis_tvalid || pending_status.size() != 0);
    endtask

    task automatic write_reg(logic [sbc_pkg::CFG_ADDR_W-1:0] idx,
                             logic [sbc_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            sbc_pkg::REG_INITIAL_SPINS: cfg_initial         = val[sbc_pkg::SPIN_W-1:0];
            sbc_pkg::REG_MIN_SPINS:     cfg.min_spins       = val[sbc_pkg::SPIN_W-1:0];
            sbc_pkg::REG_MAX_SPINS:     cfg.max_spins       = val[sbc_pkg::SPIN_W-1:0];
            sbc_pkg::REG_SPINS_INC:     cfg.spins_increment = val[sbc_pkg::SPIN_W-1:0];
            sbc_pkg::REG_MAX_DELAYS:    cfg.max_delays      = val[sbc_pkg::SPIN_W-1:0];
            sbc_pkg::REG_MIN_DELAY:     cfg.min_delay_us    = val;
            sbc_pkg::REG_MAX_DELAY:     cfg.max_delay_us    = val;
            default: begin
            end
        endcase
    endtask

    task automatic apply_settings(logic [9:0] init_s, logic [9:0] min_s, logic [9:0] max_s,
                                  logic [9:0] inc, logic [9:0] max_d,
                                  logic [19:0] min_us, logic [19:0] max_us);
        write_reg(sbc_pkg::REG_INITIAL_SPINS, 20'(init_s));
        write_reg(sbc_pkg::REG_MIN_SPINS, 20'(min_s));
        write_reg(sbc_pkg::REG_MAX_SPINS, 20'(max_s));
        write_reg(sbc_pkg::REG_SPINS_INC, 20'(inc));
        write_reg(sbc_pkg::REG_MAX_DELAYS, 20'(max_d));
        write_reg(sbc_pkg::REG_MIN_DELAY, min_us);
        write_reg(sbc_pkg::REG_MAX_DELAY, max_us);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int n, bit tx_idle, bit rx_idle, bit hold);
        tx_idle_on = tx_idle;
        rx_idle_on = rx_idle;
        if (hold) begin
            @(posedge i_clk);
            rx_hold_req = 1'b1;
        end
        push_random(n / 2);
        // sender pause: let every result come back mid-phase
        wait_drained();
        push_random(n - n / 2);
        wait_drained();
    endtask

    initial begin
        cfg.min_spins       = sbc_pkg::RST_MIN_SPINS;
        cfg.max_spins       = sbc_pkg::RST_MAX_SPINS;
        cfg.spins_increment = sbc_pkg::RST_SPINS_INC;
        cfg.max_delays      = sbc_pkg::RST_MAX_DELAYS;
        cfg.min_delay_us    = sbc_pkg::RST_MIN_DELAY;
        cfg.max_delay_us    = sbc_pkg::RST_MAX_DELAY;
        cfg_initial         = sbc_pkg::RST_INITIAL_SPINS;
        spin_cnt            = '0;
        tally               = '0;
        pred_delay          = '0;
        budget              = sbc_pkg::RST_INITIAL_SPINS;
        stuck_q             = 1'b0;
        tx_idle_on          = 1'b1;
        rx_idle_on          = 1'b1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed events at reset settings
        push_ev(sbc_pkg::ACT_BLEND, '1, '1);
        push_ev(sbc_pkg::ACT_BLEND, '0, '0);
        // never slept: budget rises
        push_ev(sbc_pkg::ACT_ACQUIRE, FRAC_W'($urandom), SPIN_BITS'($urandom));
        // zero budget: every try sleeps
        push_ev(sbc_pkg::ACT_LOAD, FRAC_W'($urandom), '0);
        push_ev(sbc_pkg::ACT_START, FRAC_W'($urandom), SPIN_BITS'($urandom));
        push_ev(sbc_pkg::ACT_FAIL, '0, SPIN_BITS'($urandom));
        push_ev(sbc_pkg::ACT_FAIL, '1, SPIN_BITS'($urandom));
        push_ev(sbc_pkg::ACT_FAIL, 16'h8000, SPIN_BITS'($urandom));
        // budget below minimum stays
        push_ev(sbc_pkg::ACT_ACQUIRE, FRAC_W'($urandom), SPIN_BITS'($urandom));
        // wait state survives acquire
        push_ev(sbc_pkg::ACT_FAIL, FRAC_W'($urandom), SPIN_BITS'($urandom));
        push_ev(ACT_RSVD5, FRAC_W'($urandom), SPIN_BITS'($urandom));
        push_ev(ACT_RSVD6, '1, '1);
        push_ev(ACT_RSVD7, '0, '0);
        // budget above maximum
        push_ev(sbc_pkg::ACT_LOAD, FRAC_W'($urandom), '1);
        push_ev(sbc_pkg::ACT_START, FRAC_W'($urandom), SPIN_BITS'($urandom));
        // not raised past maximum
        push_ev(sbc_pkg::ACT_ACQUIRE, FRAC_W'($urandom), SPIN_BITS'($urandom));
        push_ev(sbc_pkg::ACT_LOAD, FRAC_W'($urandom), 10'd1);
        push_ev(sbc_pkg::ACT_FAIL, FRAC_W'($urandom), SPIN_BITS'($urandom));
        push_ev(sbc_pkg::ACT_LOAD, FRAC_W'($urandom), 10'd20);
        // slept: budget falls by one
        push_ev(sbc_pkg::ACT_ACQUIRE, FRAC_W'($urandom), SPIN_BITS'($urandom));
        push_ev(sbc_pkg::ACT_BLEND, '1, '1);
        push_ev(sbc_pkg::ACT_START, FRAC_W'($urandom), SPIN_BITS'($urandom));
        push_ev(sbc_pkg::ACT_BLEND, FRAC_W'($urandom), SPIN_BITS'($urandom));
        wait_drained();

        // Low extremes: zero minimum delay, no sleeps allowed before stuck
        apply_settings(10'd1, 10'd0, 10'd1023, 10'd1023, 10'd0, 20'd0, 20'hFFFFF);
        write_reg(REG_NONE, CFG_BITS'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        run_phase(80, 1'b1, 1'b1, 1'b0);

        // High extremes: inverted spin bounds, delay always wraps
        apply_settings(10'd1023, 10'd1023, 10'd0, 10'd0, 10'd1023, 20'hFFFFF, 20'd1);
        run_phase(80, 1'b0, 1'b0, 1'b0);

        // Tight window with a long receiver hold-off
        apply_settings(10'd50, 10'd2, 10'd50, 10'd7, 10'd3, 20'd1, 20'd1000);
        run_phase(80, 1'b0, 1'b1, 1'b1);

        apply_settings(10'd5, 10'd1, 10'd1023, 10'd1, 10'd1, 20'd1, 20'hFFFFF);
        run_phase(80, 1'b1, 1'b0, 1'b0);

        apply_settings(SPIN_BITS'($urandom), SPIN_BITS'($urandom), SPIN_BITS'($urandom),
                       SPIN_BITS'($urandom), SPIN_BITS'($urandom),
                       CFG_BITS'($urandom), CFG_BITS'($urandom));
        run_phase(80, 1'b1, 1'b1, 1'b0);

        apply_settings(SPIN_BITS'($urandom), SPIN_BITS'($urandom_range(8)),
                       SPIN_BITS'($urandom_range(200, 20)),
                       SPIN_BITS'($urandom_range(30)), SPIN_BITS'($urandom_range(6)),
                       CFG_BITS'($urandom_range(500, 1)),
                       CFG_BITS'($urandom_range(20000, 100)));
        run_phase(80, 1'b1, 1'b1, 1'b0);

        repeat (8) @(posedge i_clk);
        if (n_err == 0 && pending_status.size() == 0)
            $display("tb_spin_backoff_controller OK");
        else
            $display("tb_spin_backoff_controller NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/sbc_pkg.sv
sv/sbc_cfg.sv
sv/sbc_step.sv
sv/spin_backoff_controller.sv
sv/sbc_checker.sv
bench/tb_spin_backoff_controller.sv
